// ===== design/csm_pkg.sv =====
// Shared types and codes for the contiguous sublist matcher.
// No dependencies; compiled first.
`default_nettype none

package csm_pkg;

	// Input word kinds
	localparam logic ACT_PATTERN = 1'b0;
	localparam logic ACT_TEXT    = 1'b1;

	// Cells per OR group in the hit reduction
	localparam int GRP_W = 32;

	// Broadcast controls for every cell of the chain
	typedef struct packed {
		logic pwr;   // a pattern word is stored in some cell this cycle
		logic clr;   // new job: drop all match flags
		logic txt;   // a text word is accepted this cycle
		logic last;  // the accepted word ends its list
	} cell_ctl_t;

	// Per-word side information handed to the result stage
	typedef struct packed {
		logic vld;
		logic txt;
		logic last;
		logic newjob;
		logic empty;
		logic ovf;
	} res_in_t;

endpackage

`default_nettype wire

// ===== design/csm_ifs.sv =====
// Handshake channels of the matcher: input words and result words.
// Standalone; used by the top level and the result stage.
`default_nettype none

interface csm_in_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] value;
	logic               last_of_list;

	modport source(output valid, action, value, last_of_list, input ready);
	modport sink(input valid, action, value, last_of_list, output ready);
endinterface

interface csm_out_if;
	logic valid;
	logic ready;
	logic found;
	logic pattern_overflow;

	modport source(output valid, found, pattern_overflow, input ready);
	modport sink(input valid, found, pattern_overflow, output ready);
endinterface

`default_nettype wire

// ===== design/contiguous_sublist_matcher.sv =====
// Top level of the contiguous sublist matcher: job control, cell chain, hit reduction.
// Depends on csm_pkg, csm_ifs, csm_cell and csm_result.
`default_nettype none

// Pattern words (action 0) fill a chain of MAX_PATTERN cells, one element per cell;
// words past the chain's end are dropped and reported as pattern_overflow. Text
// words (action 1) then stream through the chain, one word per clock while ready
// is high: every cell compares its element with the word and takes its left
// neighbor's match flag, so a flag at cell i means the first i+1 pattern elements
// end at this word. The word with last_of_list set in a text list yields one result
// word, registered through the s1 stage and then the output register. A pattern word
// that follows a closed pattern or a text list starts a new job; a further text list
// reuses the stored pattern. Input is taken every clock; ready drops only while an
// end-of-text result waits behind a result word that the sink has not yet taken.
module contiguous_sublist_matcher #(
	parameter int MAX_PATTERN = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	csm_in_if.sink    din,
	csm_out_if.source dout
);
	import csm_pkg::*;

	localparam int LW   = $clog2(MAX_PATTERN + 1);
	localparam int NGRP = (MAX_PATTERN + GRP_W - 1) / GRP_W;

	logic [LW-1:0]          len_q;
	logic                   ovf_q;
	logic                   closed_q;
	logic                   started_q;

	logic                   acc;
	logic                   pat_acc;
	logic                   txt_acc;
	logic                   newjob;
	logic [LW-1:0]          base_len;
	logic                   room;
	logic                   stall;
	cell_ctl_t              ctl;
	res_in_t                s0;

	logic [MAX_PATTERN-1:0] flags;
	logic [MAX_PATTERN-1:0] tails;
	logic [MAX_PATTERN-1:0] hits;
	logic [NGRP*GRP_W-1:0]  hit_pad;
	logic [NGRP-1:0]        grp_hit;

	always_comb begin
		acc      = din.valid & din.ready;
		pat_acc  = acc & (din.action == ACT_PATTERN);
		txt_acc  = acc & (din.action == ACT_TEXT);
		newjob   = closed_q | started_q;
		base_len = newjob ? '0 : len_q;
		room     = base_len < LW'(MAX_PATTERN);

		ctl.pwr  = pat_acc & room;
		ctl.clr  = pat_acc & newjob;
		ctl.txt  = txt_acc;
		ctl.last = din.last_of_list;

		s0.vld    = acc;
		s0.txt    = din.action == ACT_TEXT;
		s0.last   = din.last_of_list;
		s0.newjob = newjob & (din.action == ACT_PATTERN);
		s0.empty  = len_q == '0;
		s0.ovf    = ovf_q;
	end

	assign din.ready = ~stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			ovf_q     <= 1'b0;
			closed_q  <= 1'b0;
			started_q <= 1'b0;
		end else if (pat_acc) begin
			len_q     <= room ? LW'(base_len + 1'b1) : base_len;
			ovf_q     <= room ? (ovf_q & ~newjob) : 1'b1;
			closed_q  <= din.last_of_list;
			started_q <= 1'b0;
		end else if (txt_acc) begin
			closed_q  <= 1'b1;
			started_q <= ~din.last_of_list;
		end
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic prev;
		if (i == 0) begin : g_head
			assign prev = 1'b1;
		end else begin : g_body
			assign prev = flags[i-1];
		end

		csm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.wr        (ctl.pwr && (base_len == LW'(i))),
			.value     (din.value),
			.prev_flag (prev),
			.flag      (flags[i]),
			.tail      (tails[i]),
			.hit       (hits[i])
		);
	end

	// group ORs feed the result stage register
	assign hit_pad = (NGRP*GRP_W)'(hits);
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		assign grp_hit[g] = |hit_pad[g*GRP_W +: GRP_W];
	end

	csm_result #(
		.NGRP (NGRP)
	) u_result (
		.clk     (clk),
		.arst_n  (arst_n),
		.s0      (s0),
		.grp_hit (grp_hit),
		.stall   (stall),
		.dout    (dout)
	);

`ifndef SYNTH
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_PATTERN))
		else $error("pattern length beyond store");

	a_tail_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tails))
		else $error("more than one tail cell");

	a_ovf_set: assert property (@(posedge clk) disable iff (!arst_n)
		(pat_acc && !newjob && len_q == LW'(MAX_PATTERN)) |=> ovf_q)
		else $error("dropped pattern word not flagged");

	a_job_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pat_acc && newjob) |=> (flags == '0 && len_q == LW'(1)))
		else $error("new job left stale match state");
`endif

endmodule

`default_nettype wire

// ===== design/csm_cell.sv =====
// One matcher cell: a stored pattern element, its partial match flag and tail mark.
// Depends on csm_pkg.
`default_nettype none

module csm_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire csm_pkg::cell_ctl_t ctl,
	input  wire logic               wr,
	input  wire logic [31:0]        value,
	input  wire logic               prev_flag,
	output logic                    flag,
	output logic                    tail,
	output logic                    hit
);
	import csm_pkg::*;

	logic [31:0] elem_q;
	logic        flag_q;
	logic        tail_q;
	logic        flag_next;

	assign flag_next = prev_flag & (elem_q == value);
	assign flag      = flag_q;
	assign tail      = tail_q;
	// the whole pattern ends here exactly when the tail cell matches
	assign hit       = ctl.txt & flag_next & tail_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			elem_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			tail_q <= 1'b0;
		end else begin
			if (ctl.clr || (ctl.txt && ctl.last)) begin
				flag_q <= 1'b0;
			end else if (ctl.txt) begin
				flag_q <= flag_next;
			end
			if (ctl.pwr) begin
				tail_q <= wr;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/csm_result.sv =====
// Result stage: registered group hits, found accumulation and output register.
// Depends on csm_pkg and csm_out_if.
`default_nettype none

module csm_result #(
	parameter int NGRP = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire csm_pkg::res_in_t   s0,
	input  wire logic [NGRP-1:0]    grp_hit,
	output logic                    stall,
	csm_out_if.source               dout
);
	import csm_pkg::*;

	logic            vld_s1;
	logic            txt_s1;
	logic            last_s1;
	logic            newjob_s1;
	logic            empty_s1;
	logic            ovf_s1;
	logic [NGRP-1:0] grp_s1;
	logic            found_q;
	logic            out_vld_q;
	logic            out_found_q;
	logic            out_ovf_q;
	logic            found_now;
	logic            emit;

	always_comb begin
		stall     = vld_s1 & txt_s1 & last_s1 & out_vld_q & ~dout.ready;
		found_now = found_q | (|grp_s1) | empty_s1;
		emit      = vld_s1 & txt_s1 & last_s1 & ~stall;
	end

	assign dout.valid            = out_vld_q;
	assign dout.found            = out_found_q;
	assign dout.pattern_overflow = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (!stall) begin
				vld_s1 <= s0.vld;
			end
			if (vld_s1 && !stall) begin
				if (txt_s1) begin
					found_q <= last_s1 ? 1'b0 : found_now;
				end else if (newjob_s1) begin
					found_q <= 1'b0;
				end
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			txt_s1    <= s0.txt;
			last_s1   <= s0.last;
			newjob_s1 <= s0.newjob;
			empty_s1  <= s0.empty;
			ovf_s1    <= s0.ovf;
			grp_s1    <= grp_hit;
		end
		if (emit) begin
			out_found_q <= found_now;
			out_ovf_q   <= ovf_s1;
		end
	end

endmodule

`default_nettype wire

// ===== dv/csm_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the contiguous sublist matcher: watches both channels, keeps its
// own match chain, and compares each result word. Depends on csm_pkg and csm_ifs.

module csm_checker #(
	parameter int MAX_PATTERN = 64
) (
	input  logic clk,
	input  logic arst_n,
	csm_in_if    din,
	csm_out_if   dout,
	output int   errors,
	output int   pending,
	output int   words_seen,
	output int   results_seen,
	output int   found_seen,
	output int   ovf_seen
);
	import csm_pkg::*;

	typedef struct packed {
		logic found;
		logic ovf;
	} match_verdict_t;

	logic [31:0]            pat_mem [0:MAX_PATTERN-1];
	int                     pat_len;
	bit [MAX_PATTERN-1:0]   prefix_hits;
	bit                     found_flag;
	bit                     ovf_flag;
	bit                     pat_closed;
	bit                     text_busy;
	match_verdict_t         verdict_q[$];

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		errors++;
	endtask

	function automatic void start_job();
		pat_len     = 0;
		prefix_hits = '0;
		found_flag  = 1'b0;
		ovf_flag    = 1'b0;
		pat_closed  = 1'b0;
		text_busy   = 1'b0;
	endfunction

	// Advance the match chain by one accepted word; queue a verdict on end of text.
	function automatic void advance_matcher(logic act, logic [31:0] val, logic last);
		match_verdict_t v;
		int i;
		if (act == ACT_PATTERN) begin
			if (pat_closed || text_busy)
				start_job();
			if (pat_len < MAX_PATTERN) begin
				pat_mem[pat_len] = val;
				pat_len++;
			end else begin
				ovf_flag = 1'b1;
			end
			if (last)
				pat_closed = 1'b1;
		end else begin
			text_busy  = 1'b1;
			pat_closed = 1'b1;
			if (pat_len == 0) begin
				// nothing stored: trivially present
				found_flag = 1'b1;
			end else begin
				for (i = pat_len - 1; i > 0; i--)
					prefix_hits[i] = prefix_hits[i-1] && (pat_mem[i] == val);
				prefix_hits[0] = (pat_mem[0] == val);
				if (prefix_hits[pat_len-1])
					found_flag = 1'b1;
			end
			if (last) begin
				v.found = found_flag;
				v.ovf   = ovf_flag;
				verdict_q.push_back(v);
				prefix_hits = '0;
				found_flag  = 1'b0;
				text_busy   = 1'b0;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		match_verdict_t want;
		if (!arst_n) begin
			start_job();
			verdict_q.delete();
			errors       = 0;
			pending      = 0;
			words_seen   = 0;
			results_seen = 0;
			found_seen   = 0;
			ovf_seen     = 0;
		end else begin
			// a result word is registered after its input word, so check before predicting
			if (dout.valid && dout.ready) begin
				results_seen++;
				if (dout.found)
					found_seen++;
				if (dout.pattern_overflow)
					ovf_seen++;
				if (verdict_q.size() == 0) begin
					report_mismatch("result word with no verdict outstanding");
				end else begin
					want = verdict_q.pop_front();
					if (dout.found !== want.found)
						report_mismatch($sformatf("found: got %b, want %b",
							dout.found, want.found));
					if (dout.pattern_overflow !== want.ovf)
						report_mismatch($sformatf("pattern_overflow: got %b, want %b",
							dout.pattern_overflow, want.ovf));
				end
			end
			if (din.valid && din.ready) begin
				words_seen++;
				advance_matcher(din.action, din.value, din.last_of_list);
			end
			pending = verdict_q.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the matcher testbench: clock, reset, word stimulus and result sink.
// Depends on csm_pkg, csm_ifs, the matcher RTL and csm_checker.

module testbench;
	import csm_pkg::*;

	localparam int PAT_DEPTH = 64;
	localparam int N_WORDS   = 850;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n;

	csm_in_if  din_ch();
	csm_out_if dout_ch();

	int errors, pending, words_seen, results_seen, found_seen, ovf_seen;

	int          words_sent;
	int          jobs;
	bit          send_dense;
	bit          take_dense;
	int          hold_req;
	int          holds_done;
	logic [31:0] cur_pat[$];

	contiguous_sublist_matcher #(.MAX_PATTERN(PAT_DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	csm_checker #(.MAX_PATTERN(PAT_DEPTH)) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.din          (din_ch),
		.dout         (dout_ch),
		.errors       (errors),
		.pending      (pending),
		.words_seen   (words_seen),
		.results_seen (results_seen),
		.found_seen   (found_seen),
		.ovf_seen     (ovf_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic put_word(logic act, logic [31:0] val, logic last);
		int gap;
		gap = send_dense ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			din_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		din_ch.valid        <= 1'b1;
		din_ch.action       <= act;
		din_ch.value        <= val;
		din_ch.last_of_list <= last;
		do @(posedge clk); while (!(din_ch.valid && din_ch.ready));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_list(logic act, logic [31:0] vals[$], bit close);
		int k;
		for (k = 0; k < vals.size(); k++)
			put_word(act, vals[k], close && (k == vals.size() - 1));
	endtask

	task automatic send_pattern(int len, bit close, bit narrow, logic [31:0] base);
		int k;
		logic [31:0] v;
		cur_pat.delete();
		for (k = 0; k < len; k++) begin
			v = narrow ? (base ^ $urandom_range(0, 3)) : $urandom;
			cur_pat.push_back(v);
			put_word(ACT_PATTERN, v, close && (k == len - 1));
		end
	endtask

	// Text over a small alphabet around base, optionally with the stored pattern planted.
	task automatic send_text(int len, bit close, bit embed, logic [31:0] base);
		int plen, at, k;
		logic [31:0] v;
		plen = (cur_pat.size() > PAT_DEPTH) ? PAT_DEPTH : cur_pat.size();
		if (plen == 0)
			embed = 1'b0;
		if (embed && len < plen)
			len = plen + $urandom_range(0, 3);
		at = embed ? $urandom_range(0, len - plen) : 0;
		for (k = 0; k < len; k++) begin
			if (embed && k >= at && k < at + plen)
				v = cur_pat[k-at];
			else
				v = base ^ $urandom_range(0, 3);
			put_word(ACT_TEXT, v, close && (k == len - 1));
		end
	endtask

	task automatic drain_results();
		din_ch.valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	// Result sink: random stalls per word, calm stretches, and long holds on request.
	initial begin
		int gap;
		dout_ch.ready = 1'b0;
		holds_done    = 0;
		take_dense    = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (holds_done != hold_req) begin
				dout_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				holds_done++;
			end
			if ($urandom_range(0, 9) == 0)
				take_dense = !take_dense;
			gap = take_dense ? 0 : $urandom_range(0, 7);
			if (gap != 0) begin
				dout_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			dout_ch.ready <= 1'b1;
			do @(posedge clk); while (!(dout_ch.valid && dout_ch.ready));
		end
	end

	initial begin
		int plen, ntext, t, kind, r, k;
		bit narrow;
		logic [31:0] base;
		din_ch.valid        = 1'b0;
		din_ch.action       = ACT_PATTERN;
		din_ch.value        = '0;
		din_ch.last_of_list = 1'b0;
		arst_n              = 1'b0;
		words_sent          = 0;
		jobs                = 0;
		hold_req            = 0;
		send_dense          = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// text with nothing stored yet
		send_list(ACT_TEXT, '{32'h0000_0000}, 1'b1);
		// extreme values, then a second text list against the same pattern
		send_list(ACT_PATTERN, '{32'h8000_0000, 32'h7fff_ffff}, 1'b1);
		send_list(ACT_TEXT, '{32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff}, 1'b1);
		send_list(ACT_TEXT, '{32'h7fff_ffff, 32'h8000_0000}, 1'b1);
		// text arrives while the pattern is still open
		send_list(ACT_PATTERN, '{32'hffff_ffff}, 1'b0);
		send_list(ACT_TEXT, '{32'hffff_ffff}, 1'b1);
		// a pattern word cuts a text list short
		send_list(ACT_PATTERN, '{32'd1, 32'd2, 32'd3}, 1'b1);
		send_list(ACT_TEXT, '{32'd1, 32'd2}, 1'b0);
		send_list(ACT_PATTERN, '{32'd5}, 1'b1);
		send_list(ACT_TEXT, '{32'd5}, 1'b1);
		// a second pattern list after a closed one replaces it
		send_list(ACT_PATTERN, '{32'd9}, 1'b1);
		send_list(ACT_PATTERN, '{32'd9, 32'd0}, 1'b1);
		send_list(ACT_TEXT, '{32'd9}, 1'b1);
		// overlapping prefixes must restart correctly
		send_list(ACT_PATTERN, '{32'd0, 32'd0, 32'd1}, 1'b1);
		send_list(ACT_TEXT, '{32'd0, 32'd0, 32'd0, 32'd1}, 1'b1);

		while (words_sent < N_WORDS) begin
			jobs++;
			if ($urandom_range(0, 5) == 0)
				send_dense = !send_dense;
			r = $urandom_range(0, 99);
			if (jobs == 1)
				plen = PAT_DEPTH;
			else if (jobs == 2)
				plen = PAT_DEPTH + 2;
			else if (r < 70)
				plen = $urandom_range(1, 6);
			else if (r < 90)
				plen = $urandom_range(7, 20);
			else if (r < 97)
				plen = $urandom_range(21, PAT_DEPTH);
			else
				plen = $urandom_range(PAT_DEPTH + 1, PAT_DEPTH + 8);
			base   = $urandom;
			narrow = ($urandom_range(0, 9) != 0);
			// mostly well-formed jobs; a few leave the pattern or the last text open
			kind   = $urandom_range(0, 19);
			send_pattern(plen, kind != 1, narrow, base);
			ntext = $urandom_range(1, 3);
			for (t = 0; t < ntext; t++)
				send_text($urandom_range(1, 16), !(kind == 2 && t == ntext - 1),
					$urandom_range(0, 1), base);

			if (jobs == 12 || jobs == 60) begin
				// hold the sink off while short text lists pile up
				hold_req++;
				send_dense = 1'b1;
				for (k = 0; k < 20; k++)
					put_word(ACT_TEXT, base ^ $urandom_range(0, 3), 1'b1);
			end
			if (jobs % 23 == 0)
				drain_results();
		end

		din_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);
		$display("Covered %0d input words in %0d random jobs after the directed cases.",
			words_seen, jobs);
		$display("Checked %0d result words: %0d found, %0d with a truncated pattern.",
			results_seen, found_seen, ovf_seen);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Roughly ten times the slowest legal run, long holds included.
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/csm_pkg.sv
design/csm_ifs.sv
design/csm_cell.sv
design/csm_result.sv
design/contiguous_sublist_matcher.sv
dv/csm_checker.sv
dv/testbench.sv
